@@ design/r2ifft_pkg.sv @@
// ----------------------------------------------------------------------------
// r2ifft_pkg - shared constants, types and functions of the inverse FFT core
// Sizes, state codes, twiddle table and the butterfly bus types.
// ----------------------------------------------------------------------------
package r2ifft_pkg;

   localparam int MaxPoints = 64;
   localparam int AddrBits  = 6;
   localparam int DataBits  = 16;
   localparam int WordBits  = 2 * DataBits;
   localparam int LogBits   = 3;
   localparam int CntBits   = AddrBits + 1;

   // sequencer states
   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_REV   = 3'd1;
   localparam logic [2:0] ST_BFLY  = 3'd2;
   localparam logic [2:0] ST_OUT   = 3'd3;

   // butterfly unit phases
   localparam logic [2:0] PH_RD_A  = 3'd0;
   localparam logic [2:0] PH_RD_B  = 3'd1;
   localparam logic [2:0] PH_MUL   = 3'd2;
   localparam logic [2:0] PH_WR_P  = 3'd3;
   localparam logic [2:0] PH_WR_Q  = 3'd4;

   typedef logic signed [DataBits-1:0] sample_type;

   typedef struct packed {
      logic signed [DataBits:0] wc;
      logic signed [DataBits:0] ws;
   } twiddle_type;

   // quarter wave cosine table, 17 entries
   function automatic logic [15:0] quarter_cos(input logic [4:0] k);
      logic [15:0] v;
      case (k)
         5'd0:  v = 16'd32767;
         5'd1:  v = 16'd32610;
         5'd2:  v = 16'd32138;
         5'd3:  v = 16'd31357;
         5'd4:  v = 16'd30274;
         5'd5:  v = 16'd28899;
         5'd6:  v = 16'd27246;
         5'd7:  v = 16'd25330;
         5'd8:  v = 16'd23170;
         5'd9:  v = 16'd20788;
         5'd10: v = 16'd18205;
         5'd11: v = 16'd15447;
         5'd12: v = 16'd12540;
         5'd13: v = 16'd9512;
         5'd14: v = 16'd6393;
         5'd15: v = 16'd3212;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // exp(+j*2*pi*k/64) for k in 0..31
   function automatic twiddle_type twiddle(input logic [4:0] k);
      twiddle_type w;
      if (k <= 5'd16) begin
         w.wc = $signed({1'b0, quarter_cos(k)});
         w.ws = $signed({1'b0, quarter_cos(5'd16 - k)});
      end else begin
         w.wc = -$signed({1'b0, quarter_cos(5'd0 - k)});
         w.ws = $signed({1'b0, quarter_cos(k - 5'd16)});
      end
      return w;
   endfunction

   // saturate a widened value to the sample range
   function automatic sample_type sat(input logic signed [DataBits+1:0] v);
      sample_type r;
      if (v > $signed({{3{1'b0}}, {(DataBits-1){1'b1}}}))
         r = {1'b0, {(DataBits-1){1'b1}}};
      else if (v < $signed({{3{1'b1}}, {(DataBits-1){1'b0}}}))
         r = {1'b1, {(DataBits-1){1'b0}}};
      else
         r = v[DataBits-1:0];
      return r;
   endfunction

   // butterfly unit control
   typedef struct packed {
      logic                start;
      logic [AddrBits-1:0] p_addr;
      logic [AddrBits-1:0] q_addr;
      logic [4:0]          tw_index;
   } bfly_cmd_type;

endpackage

@@ design/r2ifft_stream_if.sv @@
// ----------------------------------------------------------------------------
// r2ifft_stream_if - valid/ready channels of the inverse FFT core
// Input sample channel and result channel.
// ----------------------------------------------------------------------------
interface r2ifft_req_if;
   logic valid;
   logic ready;
   logic [r2ifft_pkg::DataBits-1:0] sample_real;
   logic [r2ifft_pkg::DataBits-1:0] sample_imag;
   modport source (output valid, output sample_real, output sample_imag, input ready);
   modport sink   (input valid, input sample_real, input sample_imag, output ready);
endinterface

interface r2ifft_rsp_if;
   logic valid;
   logic ready;
   logic [r2ifft_pkg::DataBits-1:0] result_real;
   logic [r2ifft_pkg::DataBits-1:0] result_imag;
   logic frame_end;
   modport source (output valid, output result_real, output result_imag,
                   output frame_end, input ready);
   modport sink   (input valid, input result_real, input result_imag,
                   input frame_end, output ready);
endinterface

@@ design/r2ifft_ram.sv @@
// ----------------------------------------------------------------------------
// r2ifft_ram - generic single port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module r2ifft_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_ff <= mem_ff[addr];
   end
   assign rd_data = rd_ff;
endmodule

@@ design/r2ifft_bfly.sv @@
// ----------------------------------------------------------------------------
// r2ifft_bfly - shared butterfly unit
// Reads a and b, multiplies b by the twiddle, writes both halved outputs.
// ----------------------------------------------------------------------------
module r2ifft_bfly (
   input  logic                                clock,
   input  logic                                reset,
   input  r2ifft_pkg::bfly_cmd_type            cmd,
   output logic                                busy,
   output logic                                done,
   output logic                                mem_wr,
   output logic [r2ifft_pkg::AddrBits-1:0]     mem_addr,
   output logic [r2ifft_pkg::WordBits-1:0]     mem_wdata,
   input  logic [r2ifft_pkg::WordBits-1:0]     mem_rdata
);
   localparam int D = r2ifft_pkg::DataBits;

   logic [2:0] ph_ff, ph_in;
   logic       act_ff, act_in;
   logic [r2ifft_pkg::AddrBits-1:0] p_ff, q_ff;
   logic [4:0] k_ff;
   logic signed [D-1:0] ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [D:0]   tr_ff, ti_ff;
   logic signed [2*D+2:0] sr, si;
   r2ifft_pkg::twiddle_type w;
   logic signed [D+1:0] sum_r, sum_i, dif_r, dif_i;

   // phase sequencer: start cycle reads p, then q, multiply, write p, write q
   always_comb begin
      act_in = act_ff;
      ph_in  = ph_ff;
      if (!act_ff) begin
         if (cmd.start) begin
            act_in = 1'b1;
            ph_in  = r2ifft_pkg::PH_RD_A;
         end
      end else begin
         case (ph_ff)
            r2ifft_pkg::PH_RD_A: ph_in = r2ifft_pkg::PH_RD_B;
            r2ifft_pkg::PH_RD_B: ph_in = r2ifft_pkg::PH_MUL;
            r2ifft_pkg::PH_MUL:  ph_in = r2ifft_pkg::PH_WR_P;
            r2ifft_pkg::PH_WR_P: ph_in = r2ifft_pkg::PH_WR_Q;
            default:             act_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         ph_ff  <= r2ifft_pkg::PH_RD_A;
      end else begin
         act_ff <= act_in;
         ph_ff  <= ph_in;
      end
   end

   assign busy = act_ff;
   assign done = act_ff && (ph_ff == r2ifft_pkg::PH_WR_Q);

   // twiddle product, rounded at bit 15
   assign w  = r2ifft_pkg::twiddle(k_ff);
   assign sr = br_ff * w.wc - bi_ff * w.ws + (2*D+3)'(16384);
   assign si = br_ff * w.ws + bi_ff * w.wc + (2*D+3)'(16384);

   // datapath registers; a arrives in RD_A, b in RD_B
   always_ff @(posedge clock) begin
      if (!act_ff && cmd.start) begin
         p_ff <= cmd.p_addr;
         q_ff <= cmd.q_addr;
         k_ff <= cmd.tw_index;
      end
      if (act_ff && ph_ff == r2ifft_pkg::PH_RD_A) begin
         ar_ff <= mem_rdata[2*D-1:D];
         ai_ff <= mem_rdata[D-1:0];
      end
      if (act_ff && ph_ff == r2ifft_pkg::PH_RD_B) begin
         br_ff <= mem_rdata[2*D-1:D];
         bi_ff <= mem_rdata[D-1:0];
      end
      if (act_ff && ph_ff == r2ifft_pkg::PH_MUL) begin
         tr_ff <= (D+1)'(sr >>> 15);
         ti_ff <= (D+1)'(si >>> 15);
      end
   end

   // product needs one bit more than a sample; sums two more
   assign sum_r = (D+2)'(ar_ff) + (D+2)'(tr_ff) + (D+2)'(1);
   assign sum_i = (D+2)'(ai_ff) + (D+2)'(ti_ff) + (D+2)'(1);
   assign dif_r = (D+2)'(ar_ff) - (D+2)'(tr_ff) + (D+2)'(1);
   assign dif_i = (D+2)'(ai_ff) - (D+2)'(ti_ff) + (D+2)'(1);

   // memory port
   always_comb begin
      mem_wr    = 1'b0;
      mem_addr  = p_ff;
      mem_wdata = '0;
      if (!act_ff) begin
         mem_addr = cmd.p_addr;
      end else begin
         case (ph_ff)
            r2ifft_pkg::PH_RD_A: mem_addr = q_ff;
            r2ifft_pkg::PH_WR_P: begin
               mem_wr    = 1'b1;
               mem_addr  = p_ff;
               mem_wdata = {r2ifft_pkg::sat(sum_r >>> 1), r2ifft_pkg::sat(sum_i >>> 1)};
            end
            r2ifft_pkg::PH_WR_Q: begin
               mem_wr    = 1'b1;
               mem_addr  = q_ff;
               mem_wdata = {r2ifft_pkg::sat(dif_r >>> 1), r2ifft_pkg::sat(dif_i >>> 1)};
            end
            default: mem_addr = p_ff;
         endcase
      end
   end
endmodule

@@ design/radix2_inverse_fft_core.sv @@
// ----------------------------------------------------------------------------
// radix2_inverse_fft_core - radix-2 DIT inverse FFT, Q1.15, 1/N scaling
// Loads N samples, reorders, runs the butterfly stages, streams results.
// Frames are handled one at a time: samples are taken only in the load state,
//   one load per cycle while the sender holds valid; the bit-reversal swaps and
//   the butterflies share the single RAM port.
// Reset: synchronous; clears sequencer, load count, length register (to 6).
// ----------------------------------------------------------------------------
module radix2_inverse_fft_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [2:0]           csr_wr_data,
   r2ifft_req_if.sink           req,
   r2ifft_rsp_if.source         rsp
);
   localparam int A = r2ifft_pkg::AddrBits;
   localparam int D = r2ifft_pkg::DataBits;

   logic [2:0]   st_ff, st_in;
   logic [2:0]   lg_ff, lg_in;
   logic [2:0]   lg_eff;
   logic [A:0]   cnt_ff, cnt_in;
   logic [A-1:0] j_ff, j_in;
   logic [2:0]   m_ff, m_in;
   logic [1:0]   sub_ff, sub_in;
   logic [r2ifft_pkg::WordBits-1:0] hold_ff, hold_in;
   logic         ov_ff, ov_in;
   logic [r2ifft_pkg::WordBits-1:0] ob_ff, ob_in;
   logic         oe_ff, oe_in;

   logic         mwr;
   logic [A-1:0] maddr;
   logic [r2ifft_pkg::WordBits-1:0] mwd, mrd;

   r2ifft_pkg::bfly_cmd_type cmd;
   logic bbusy, bdone, bwr;
   logic [A-1:0] baddr;
   logic [r2ifft_pkg::WordBits-1:0] bwd;

   logic [A:0]   n_pts;
   logic [A-1:0] rev;
   logic [A-1:0] half, grp, p_a, q_a;

   assign lg_eff = (lg_ff == 3'd0) ? 3'd1 : ((lg_ff > 3'd6) ? 3'd6 : lg_ff);
   assign n_pts  = (A+1)'(1) << lg_eff;

   // bit reversal of the count over lg_eff bits
   always_comb begin
      rev = '0;
      for (int b = 0; b < A; b++)
         if (b < int'(lg_eff)) rev[int'(lg_eff) - 1 - b] = cnt_ff[b];
   end

   // butterfly addresses: j counts pairs; insert a zero at bit m-1
   assign half = A'(1) << (m_ff - 3'd1);
   assign grp  = ((j_ff >> (m_ff - 3'd1)) << m_ff);
   assign p_a  = grp | (j_ff & (half - A'(1)));
   assign q_a  = p_a | half;

   assign cmd.start    = (st_ff == r2ifft_pkg::ST_BFLY) && !bbusy && (sub_ff == 2'd0);
   assign cmd.p_addr   = p_a;
   assign cmd.q_addr   = q_a;
   assign cmd.tw_index = 5'((j_ff & (half - A'(1))) << (3'd6 - m_ff));

   assign req.ready = (st_ff == r2ifft_pkg::ST_LOAD);
   assign rsp.valid = ov_ff;
   assign rsp.result_real = ob_ff[2*D-1:D];
   assign rsp.result_imag = ob_ff[D-1:0];
   assign rsp.frame_end   = oe_ff;

   // sequencer
   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; j_in = j_ff; m_in = m_ff; sub_in = sub_ff;
      hold_in = hold_ff; ov_in = ov_ff; ob_in = ob_ff; oe_in = oe_ff;
      lg_in = lg_ff;
      mwr = 1'b0; maddr = cnt_ff[A-1:0]; mwd = '0;
      if (rsp.valid && rsp.ready) ov_in = 1'b0;
      case (st_ff)
         r2ifft_pkg::ST_LOAD: begin
            mwd = {req.sample_real, req.sample_imag};
            if (req.valid) begin
               mwr = 1'b1;
               if (cnt_ff + (A+1)'(1) >= n_pts) begin
                  st_in = r2ifft_pkg::ST_REV; cnt_in = '0; sub_in = '0;
               end else cnt_in = cnt_ff + (A+1)'(1);
            end
         end
         r2ifft_pkg::ST_REV: begin
            // swap i and rev(i) when rev > i: read i, read rev, write i, write rev
            case (sub_ff)
               2'd0: begin
                  maddr = cnt_ff[A-1:0];
                  if (rev > cnt_ff[A-1:0]) sub_in = 2'd1;
                  else if (cnt_ff + (A+1)'(1) >= n_pts) begin
                     st_in = r2ifft_pkg::ST_BFLY; m_in = 3'd1; j_in = '0; sub_in = '0;
                  end else cnt_in = cnt_ff + (A+1)'(1);
               end
               2'd1: begin maddr = rev; hold_in = mrd; sub_in = 2'd2; end
               2'd2: begin mwr = 1'b1; maddr = cnt_ff[A-1:0]; mwd = mrd; sub_in = 2'd3; end
               default: begin
                  mwr = 1'b1; maddr = rev; mwd = hold_ff; sub_in = 2'd0;
                  if (cnt_ff + (A+1)'(1) >= n_pts) begin
                     st_in = r2ifft_pkg::ST_BFLY; m_in = 3'd1; j_in = '0;
                  end else cnt_in = cnt_ff + (A+1)'(1);
               end
            endcase
         end
         r2ifft_pkg::ST_BFLY: begin
            mwr = bwr; maddr = baddr; mwd = bwd;
            if (bdone) begin
               if ((A+1)'(j_ff) + (A+1)'(1) >= (n_pts >> 1)) begin
                  j_in = '0;
                  if (m_ff == lg_eff) begin
                     st_in = r2ifft_pkg::ST_OUT; cnt_in = '0; sub_in = '0;
                  end else m_in = m_ff + 3'd1;
               end else j_in = j_ff + A'(1);
            end
         end
         default: begin
            // read one entry, hand it to the output register when free
            maddr = cnt_ff[A-1:0];
            if (sub_ff == 2'd0) sub_in = 2'd1;
            else if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1; ob_in = mrd;
               oe_in = (cnt_ff + (A+1)'(1) >= n_pts);
               sub_in = 2'd0;
               if (oe_in) begin st_in = r2ifft_pkg::ST_LOAD; cnt_in = '0; end
               else cnt_in = cnt_ff + (A+1)'(1);
            end
         end
      endcase
      // length write drops the partial frame
      if (csr_wr_en) begin
         lg_in = csr_wr_data; cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= r2ifft_pkg::ST_LOAD; cnt_ff <= '0; sub_ff <= '0; ov_ff <= 1'b0;
         lg_ff <= 3'd6; j_ff <= '0; m_ff <= 3'd1;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; sub_ff <= sub_in; ov_ff <= ov_in;
         j_ff <= j_in; m_ff <= m_in; lg_ff <= lg_in;
      end
   end
   always_ff @(posedge clock) begin
      hold_ff <= hold_in; ob_ff <= ob_in; oe_ff <= oe_in;
   end

   r2ifft_bfly u_bfly (
      .clock(clock), .reset(reset), .cmd(cmd), .busy(bbusy), .done(bdone),
      .mem_wr(bwr), .mem_addr(baddr), .mem_wdata(bwd), .mem_rdata(mrd)
   );

   r2ifft_ram #(.Width(r2ifft_pkg::WordBits), .Depth(r2ifft_pkg::MaxPoints)) u_ram (
      .clock(clock), .wr_en(mwr), .addr(maddr), .wr_data(mwd), .rd_data(mrd)
   );

   // checks
   a_no_ready_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff != r2ifft_pkg::ST_LOAD) |-> !req.ready) else $error("ready while busy");
   a_bfly_only: assert property (@(posedge clock) disable iff (reset)
      bbusy |-> (st_ff == r2ifft_pkg::ST_BFLY)) else $error("butterfly outside stage");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
endmodule

@@ sim/radix2_inverse_fft_core_tb.sv @@
// ----------------------------------------------------------------------------
// radix2_inverse_fft_core_tb - self-checking bench of the inverse FFT core
// Streams frames of complex samples at several transform lengths, predicts
// each frame's scaled inverse transform and compares every result transfer.
// ----------------------------------------------------------------------------
module radix2_inverse_fft_core_tb;

   localparam int CycleLimit  = 2000000;
   localparam int StallCycles = 3000;

   typedef struct packed {
      logic [r2ifft_pkg::DataBits-1:0] re;
      logic [r2ifft_pkg::DataBits-1:0] im;
   } sample_pair_type;

   typedef struct packed {
      logic [r2ifft_pkg::DataBits-1:0] re;
      logic [r2ifft_pkg::DataBits-1:0] im;
      logic                            last;
   } ifft_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_wr_data = '0;

   r2ifft_req_if req ();
   r2ifft_rsp_if rsp ();

   radix2_inverse_fft_core dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req(req.sink), .rsp(rsp.source)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [2:0]      length_reg;
   int              fill_count;
   longint          frame_re [r2ifft_pkg::MaxPoints];
   longint          frame_im [r2ifft_pkg::MaxPoints];
   ifft_point_type  expected_points [$];
   sample_pair_type pending_samples [$];
   int              error_count = 0;
   int              cycle_count = 0;

   // transfer counters: written at the rising edge, followed at the falling edge
   int              req_count = 0;
   int              req_seen = 0;
   int              rsp_count = 0;
   int              rsp_seen = 0;

   // receiver hold-off requests and the cycles left
   int              stall_asks = 0;
   int              stall_taken = 0;
   int              stall_left = 0;

   function automatic longint floor_half(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint clip16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic int active_log2();
      if (length_reg < 1) return 1;
      if (length_reg > 6) return 6;
      return length_reg;
   endfunction

   // cosine/sine pair from the package-independent quarter table
   function automatic void cos_sin(input int k, output longint wc, output longint ws);
      int qc [17];
      qc = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
             20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
      k = k & 31;
      if (k <= 16) begin
         wc = qc[k]; ws = qc[16 - k];
      end else begin
         wc = -qc[32 - k]; ws = qc[k - 16];
      end
   endfunction

   // run the in-place transform and queue the N results
   task automatic compute_inverse_fft(input int lg);
      int n, rev, half, p, q;
      longint wc, ws, tr, ti, ar, ai, br, bi, t;
      n = 1 << lg;
      for (int i = 0; i < n; i++) begin
         rev = 0;
         for (int b = 0; b < lg; b++) if (i[b]) rev |= 1 << (lg - 1 - b);
         if (rev > i) begin
            t = frame_re[i]; frame_re[i] = frame_re[rev]; frame_re[rev] = t;
            t = frame_im[i]; frame_im[i] = frame_im[rev]; frame_im[rev] = t;
         end
      end
      for (int m = 1; m <= lg; m++) begin
         half = 1 << (m - 1);
         for (int g = 0; g < n; g += 2 * half)
            for (int j = 0; j < half; j++) begin
               p = g + j; q = g + j + half;
               cos_sin(j << (6 - m), wc, ws);
               br = frame_re[q]; bi = frame_im[q];
               tr = floor_half(br * wc - bi * ws + 16384, 15);
               ti = floor_half(br * ws + bi * wc + 16384, 15);
               ar = frame_re[p]; ai = frame_im[p];
               frame_re[p] = clip16(floor_half(ar + tr + 1, 1));
               frame_im[p] = clip16(floor_half(ai + ti + 1, 1));
               frame_re[q] = clip16(floor_half(ar - tr + 1, 1));
               frame_im[q] = clip16(floor_half(ai - ti + 1, 1));
            end
      end
      for (int k = 0; k < n; k++)
         expected_points.push_back('{frame_re[k][15:0], frame_im[k][15:0], k == n - 1});
   endtask

   // accept one sample into the predicted frame
   task automatic load_sample(input sample_pair_type s);
      frame_re[fill_count] = longint'($signed(s.re));
      frame_im[fill_count] = longint'($signed(s.im));
      fill_count++;
      if (fill_count == (1 << active_log2())) begin
         fill_count = 0;
         compute_inverse_fft(active_log2());
      end
   endtask

   // sample driver
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.sample_real <= '0;
         req.sample_imag <= '0;
      end else if (!req.valid || req_seen != req_count) begin
         // transfer completed at the last rising edge: draw the next gap
         if (req.valid) begin
            req_seen = req_count;
            send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         end
         if (send_gap > 0) begin
            send_gap--;
            req.valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            req.valid <= 1'b1;
            req.sample_real <= pending_samples[0].re;
            req.sample_imag <= pending_samples[0].im;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // predictor hook on accepted samples
   always @(posedge clock)
      if (!reset && req.valid && req.ready) begin
         load_sample('{req.sample_real, req.sample_imag});
         void'(pending_samples.pop_front());
         req_count++;
      end

   // long receiver hold-off, counted on its own
   always @(negedge clock) begin
      if (stall_taken != stall_asks) begin
         stall_taken = stall_asks;
         stall_left = StallCycles;
      end else if (stall_left > 0) begin
         stall_left--;
      end
   end

   // result receiver with random back-pressure
   int recv_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp_seen != rsp_count) begin
            rsp_seen = rsp_count;
            recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
         end
         if (stall_left > 0) begin
            rsp.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      ifft_point_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         rsp_count++;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected result re=%0d im=%0d last=%0b", $time,
                     $signed(rsp.result_real), $signed(rsp.result_imag), rsp.frame_end);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            if (want.re !== rsp.result_real || want.im !== rsp.result_imag ||
                want.last !== rsp.frame_end) begin
               $display("%0t: mismatch expected re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                        $time, $signed(want.re), $signed(want.im), want.last,
                        $signed(rsp.result_real), $signed(rsp.result_imag), rsp.frame_end);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // wait until every queued sample is accepted and every result has arrived
   task automatic wait_idle();
      while (pending_samples.size() > 0 || req.valid || expected_points.size() > 0)
         @(posedge clock);
      repeat (1000) @(posedge clock);
   endtask

   task automatic write_length(input logic [2:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      length_reg = v;
      fill_count = 0;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [15:0] rand_field();
      case ($urandom_range(0, 4))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'(int'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_frames(input int frames, input int lg);
      for (int f = 0; f < frames; f++)
         for (int k = 0; k < (1 << lg); k++)
            pending_samples.push_back('{rand_field(), rand_field()});
   endtask

   initial begin
      logic [2:0] lg_list [8];
      int sent;
      length_reg = 3'd6;
      fill_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes at length 2 and 4
      write_length(3'd1);
      pending_samples.push_back('{16'h7fff, 16'h7fff});
      pending_samples.push_back('{16'h7fff, 16'h7fff});
      pending_samples.push_back('{16'h8000, 16'h8000});
      pending_samples.push_back('{16'h7fff, 16'h8000});
      pending_samples.push_back('{16'h0001, 16'hffff});
      pending_samples.push_back('{16'h0000, 16'h0000});
      wait_idle();
      write_length(3'd2);
      for (int k = 0; k < 4; k++) pending_samples.push_back('{16'h8000, 16'h7fff});
      pending_samples.push_back('{16'h7fff, 16'h0000});
      for (int k = 0; k < 3; k++) pending_samples.push_back('{16'h0000, 16'h0000});
      // partial frame dropped by the next length write
      pending_samples.push_back('{16'h1234, 16'h5678});
      wait_idle();
      // length 0 acts as 2, length 7 as 64
      write_length(3'd0);
      queue_frames(1, 1);
      wait_idle();
      write_length(3'd7);
      queue_frames(1, 6);
      // long receiver hold-off while the sender keeps offering
      stall_asks++;
      queue_frames(1, 6);
      wait_idle();

      // random frames over all lengths
      lg_list = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd3, 3'd2};
      sent = 0;
      while (sent < 280) begin
         for (int i = 0; i < 8 && sent < 280; i++) begin
            write_length(lg_list[i]);
            queue_frames(lg_list[i] == 3'd6 ? 1 : 3, lg_list[i]);
            sent += (lg_list[i] == 3'd6 ? 1 : 3) << lg_list[i];
            wait_idle();
         end
      end
      wait_idle();
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
design/r2ifft_pkg.sv
design/r2ifft_stream_if.sv
design/r2ifft_ram.sv
design/r2ifft_bfly.sv
design/radix2_inverse_fft_core.sv
sim/radix2_inverse_fft_core_tb.sv
